// File: hw/rtl/rsps_pkg.sv
// rsps_pkg: shared types and constants of the range sum / point set store
// field widths, operation and status codes, store write controls
// no dependencies
package rsps_pkg;

  localparam int unsigned POS_BITS   = 10;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned COUNT_BITS = 11;

  localparam logic [COUNT_BITS-1:0] ACTIVE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ORDER = 2'd2
  } status_e;

  // write strobes from the sequencer to the two memories
  typedef struct packed {
    logic tree_we;
    logic plain_we;
  } store_wr_t;

endpackage

// File: hw/rtl/rsps_store.sv
// rsps_store: tree partial-sum memory and plain value memory
// one write port and one registered read port each
// depends on rsps_pkg
module rsps_store import rsps_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  store_wr_t                     wr_i,
  input  logic [$clog2(DEPTH)-1:0]      tree_waddr_i,
  input  logic [$clog2(DEPTH)-1:0]      tree_raddr_i,
  input  logic [VALUE_BITS-1:0]         tree_wdata_i,
  output logic [VALUE_BITS-1:0]         tree_rdata_o,
  input  logic [$clog2(DEPTH)-1:0]      plain_addr_i,
  input  logic [VALUE_BITS-1:0]         plain_wdata_i,
  output logic [VALUE_BITS-1:0]         plain_rdata_o
);

  logic [VALUE_BITS-1:0] tree_mem  [DEPTH];
  logic [VALUE_BITS-1:0] plain_mem [DEPTH];
  logic [VALUE_BITS-1:0] tree_rdata_q;
  logic [VALUE_BITS-1:0] plain_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tree_we) begin
      tree_mem[tree_waddr_i] <= tree_wdata_i;
    end
    tree_rdata_q <= tree_mem[tree_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.plain_we) begin
      plain_mem[plain_addr_i] <= plain_wdata_i;
    end
    plain_rdata_q <= plain_mem[plain_addr_i];
  end

  assign tree_rdata_o  = tree_rdata_q;
  assign plain_rdata_o = plain_rdata_q;

endmodule

// File: hw/rtl/rsps_seq.sv
// rsps_seq: request sequencer, tree walks and result register
// drives the memory ports of rsps_store, one tree entry per cycle
// depends on rsps_pkg
module rsps_seq import rsps_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [0:0]                    op_i,
  input  logic [POS_BITS-1:0]           position_i,
  input  logic [POS_BITS-1:0]           right_end_i,
  input  logic signed [FIELD_BITS-1:0]  value_i,
  input  logic [COUNT_BITS-1:0]         active_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [FIELD_BITS-1:0]  range_sum_o,
  output logic [1:0]                    status_o,
  output store_wr_t                     mem_wr_o,
  output logic [$clog2(DEPTH)-1:0]      tree_waddr_o,
  output logic [$clog2(DEPTH)-1:0]      tree_raddr_o,
  output logic [VALUE_BITS-1:0]         tree_wdata_o,
  input  logic [VALUE_BITS-1:0]         tree_rdata_i,
  output logic [$clog2(DEPTH)-1:0]      plain_addr_o,
  output logic [VALUE_BITS-1:0]         plain_wdata_o,
  input  logic [VALUE_BITS-1:0]         plain_rdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_PLAIN = 7'b0000100,
    ST_UPD   = 7'b0001000,
    ST_QA    = 7'b0010000,
    ST_QB    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [POS_BITS-1:0]     pos_q, pos_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [VALUE_BITS-1:0]   delta_q, delta_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic [SW-1:0]           slot_q, slot_d;
  status_e                 status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  logic [FIELD_BITS-1:0]   out_sum_q, out_sum_d;
  status_e                 out_status_q, out_status_d;

  logic                    left_bad, right_bad;
  logic [SW-1:0]           right_slot, left_slot;
  logic [SW:0]             nxt_up;
  logic [SW-1:0]           nxt_dn;

  // tree slots run 1..DEPTH and sit at address slot-1
  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s);
    slot_addr = AW'(s - SW'(1));
  endfunction

  assign left_bad   = ({1'b0, position_i} >= active_count_i) || (32'(position_i) >= DEPTH_W);
  assign right_bad  = ({1'b0, right_end_i} >= active_count_i) || (32'(right_end_i) >= DEPTH_W);
  assign right_slot = SW'({1'b0, right_end_i} + 11'd1);
  assign left_slot  = SW'({1'b0, pos_q} + 11'd1);
  assign nxt_up     = {1'b0, slot_q} + {1'b0, slot_q & (~slot_q + SW'(1))};
  assign nxt_dn     = slot_q & (slot_q - SW'(1));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    pos_d        = pos_q;
    val_d        = val_q;
    delta_d      = delta_q;
    acc_d        = acc_q;
    slot_d       = slot_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    mem_wr_o     = '0;
    tree_waddr_o = slot_addr(slot_q);
    tree_raddr_o = slot_addr(slot_q);
    tree_wdata_o = tree_rdata_i + delta_q;
    plain_addr_o = AW'(pos_q);
    plain_wdata_o = val_q;

    case (state_q)
      ST_CLEAR: begin
        mem_wr_o.tree_we  = 1'b1;
        mem_wr_o.plain_we = 1'b1;
        tree_waddr_o      = clr_q;
        plain_addr_o      = clr_q;
        tree_wdata_o      = '0;
        plain_wdata_o     = '0;
        clr_d             = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          pos_d    = position_i;
          val_d    = VALUE_BITS'(value_i);
          acc_d    = '0;
          status_d = STAT_OK;
          if (left_bad || (op_i == OP_QUERY && right_bad)) begin
            status_d = STAT_RANGE;
            state_d  = ST_DONE;
          end else if (op_i == OP_QUERY) begin
            if (position_i > right_end_i) begin
              status_d = STAT_ORDER;
              state_d  = ST_DONE;
            end else begin
              slot_d       = right_slot;
              tree_raddr_o = slot_addr(right_slot);
              state_d      = ST_QA;
            end
          end else begin
            plain_addr_o = AW'(position_i);
            state_d      = ST_PLAIN;
          end
        end
      end
      ST_PLAIN: begin
        // old value is in; keep the new one and start the upward walk
        delta_d           = val_q - plain_rdata_i;
        mem_wr_o.plain_we = 1'b1;
        slot_d            = left_slot;
        tree_raddr_o      = slot_addr(left_slot);
        state_d           = ST_UPD;
      end
      ST_UPD: begin
        // write back this slot while the next one is read
        mem_wr_o.tree_we = 1'b1;
        if (nxt_up <= (SW+1)'(DEPTH)) begin
          slot_d       = SW'(nxt_up);
          tree_raddr_o = slot_addr(SW'(nxt_up));
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_QA: begin
        acc_d = acc_q + tree_rdata_i;
        if (nxt_dn != '0) begin
          slot_d       = nxt_dn;
          tree_raddr_o = slot_addr(nxt_dn);
        end else if (pos_q != '0) begin
          slot_d       = SW'(pos_q);
          tree_raddr_o = slot_addr(SW'(pos_q));
          state_d      = ST_QB;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_QB: begin
        acc_d = acc_q - tree_rdata_i;
        if (nxt_dn != '0) begin
          slot_d       = nxt_dn;
          tree_raddr_o = slot_addr(nxt_dn);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_sum_d    = FIELD_BITS'(acc_q);
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    val_q        <= val_d;
    delta_q      <= delta_d;
    acc_q        <= acc_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;
  assign status_o    = out_status_q;

endmodule

// File: hw/rtl/range_sum_point_set_store.sv
// Range sum / point set store. A binary indexed tree over DEPTH signed values
// held in two memories with registered reads (partial sums and plain values).
// A set request reads the old value, then walks the update path one tree
// entry per cycle. A query walks the prefix path of right_end+1 and then of
// position through the same tree read port. Rejected requests skip the
// memories. One request is worked on at a time; the result register lets
// the next request in while a result waits. After reset both memories are
// cleared while in_stall_o stays high. Sums wrap at VALUE_BITS bits.
// depends on rsps_pkg, rsps_seq, rsps_store
module range_sum_point_set_store import rsps_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [0:0]                    op_i,
  input  logic [POS_BITS-1:0]           position_i,
  input  logic [POS_BITS-1:0]           right_end_i,
  input  logic signed [FIELD_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [FIELD_BITS-1:0]  range_sum_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic [COUNT_BITS-1:0]         cfg_wdata_i
);

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_BITS-1:0]  active_count_q;
  store_wr_t              mem_wr;
  logic [AW-1:0]          tree_waddr, tree_raddr, plain_addr;
  logic [VALUE_BITS-1:0]  tree_wdata, tree_rdata, plain_wdata, plain_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_count_q <= cfg_wdata_i;
    end
  end

  rsps_seq #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .position_i     (position_i),
    .right_end_i    (right_end_i),
    .value_i        (value_i),
    .active_count_i (active_count_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .range_sum_o    (range_sum_o),
    .status_o       (status_o),
    .mem_wr_o       (mem_wr),
    .tree_waddr_o   (tree_waddr),
    .tree_raddr_o   (tree_raddr),
    .tree_wdata_o   (tree_wdata),
    .tree_rdata_i   (tree_rdata),
    .plain_addr_o   (plain_addr),
    .plain_wdata_o  (plain_wdata),
    .plain_rdata_i  (plain_rdata)
  );

  rsps_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .wr_i          (mem_wr),
    .tree_waddr_i  (tree_waddr),
    .tree_raddr_i  (tree_raddr),
    .tree_wdata_i  (tree_wdata),
    .tree_rdata_o  (tree_rdata),
    .plain_addr_i  (plain_addr),
    .plain_wdata_i (plain_wdata),
    .plain_rdata_o (plain_rdata)
  );

  // one request at a time: the port closes right after a request
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while another is in flight");

  // a new result only follows a cycle of busy sequencer
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request being worked on");

  // rejected requests carry a zero sum (sets do too, but only rejections are checked here)
  a_error_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_RANGE || status_o == STAT_ORDER)) |->
    (range_sum_o == '0))
    else $error("nonzero sum on a rejected request");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for range_sum_point_set_store
// directed table then random set/query traffic, checked against a plain-array predictor
// depends on rsps_pkg and the range_sum_point_set_store rtl
module tb import rsps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    op_e                   op;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   right;
    logic [FIELD_BITS-1:0] val;
  } request_t;

  typedef struct {
    logic [FIELD_BITS-1:0] sum;
    status_e               status;
  } result_t;

  typedef struct {
    row_kind_e             kind;
    request_t              req;
    logic [COUNT_BITS-1:0] count;
    bit                    typed;
    result_t               res;
  } plan_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [0:0]                   op_i        = OP_SET;
  logic [POS_BITS-1:0]          position_i  = '0;
  logic [POS_BITS-1:0]          right_end_i = '0;
  logic signed [FIELD_BITS-1:0] value_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [FIELD_BITS-1:0] range_sum_o;
  logic [1:0]                   status_o;
  logic                         cfg_we_i    = 1'b0;
  logic [COUNT_BITS-1:0]        cfg_wdata_i = '0;

  // predictor state: current value of every position and the active count
  logic [FIELD_BITS-1:0] point_value [DEPTH];
  logic [COUNT_BITS-1:0] cur_count;

  result_t   pending_results [$];
  plan_row_t stimulus_plan [$];

  int  n_errors    = 0;
  int  n_checked   = 0;
  int  n_sets      = 0;
  int  n_queries   = 0;
  int  n_rejected  = 0;
  int  n_settings  = 0;
  int  idle_cycles = 0;
  bit  quiet       = 1'b0;

  range_sum_point_set_store DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .right_end_i (right_end_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .range_sum_o (range_sum_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // range sums are taken straight from the plain values, so no tree is kept here
  function automatic void predict_result(input request_t rq, output result_t res);
    int unsigned           lim;
    logic [FIELD_BITS-1:0] acc;
    lim        = (cur_count > DEPTH) ? DEPTH : cur_count;
    res.sum    = '0;
    res.status = STAT_OK;
    if (rq.op == OP_SET) begin
      if (rq.pos >= lim) res.status = STAT_RANGE;
      else point_value[rq.pos] = rq.val;
    end else if (rq.pos >= lim || rq.right >= lim) begin
      res.status = STAT_RANGE;
    end else if (rq.pos > rq.right) begin
      res.status = STAT_ORDER;
    end else begin
      acc = '0;
      for (int k = rq.pos; k <= rq.right; k++) acc += point_value[k];
      res.sum = acc;
    end
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t make_request(input int unsigned lim);
    request_t    rq;
    int unsigned r;
    int unsigned a;
    int unsigned b;
    rq.val   = pick_value();
    rq.right = POS_BITS'($urandom_range(0, DEPTH - 1));
    rq.pos   = POS_BITS'($urandom_range(0, DEPTH - 1));
    r        = $urandom_range(0, 99);
    if (lim == 0) begin
      rq.op = (r < 45) ? OP_SET : OP_QUERY;
      return rq;
    end
    if (r < 45) begin
      rq.op = OP_SET;
      if ($urandom_range(0, 9) != 0) rq.pos = POS_BITS'($urandom_range(0, lim - 1));
      return rq;
    end
    rq.op = OP_QUERY;
    r     = $urandom_range(0, 99);
    if (r < 75) begin
      a = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 2) == 0) begin
        b = a + $urandom_range(0, 7);
        if (b > lim - 1) b = lim - 1;
      end else begin
        b = $urandom_range(a, lim - 1);
      end
      rq.pos   = POS_BITS'(a);
      rq.right = POS_BITS'(b);
    end else if (r < 85 && lim >= 2) begin
      b        = $urandom_range(0, lim - 2);
      rq.right = POS_BITS'(b);
      rq.pos   = POS_BITS'($urandom_range(b + 1, lim - 1));
    end else if (r < 95 && lim < DEPTH) begin
      // one end past the active count, the other anywhere
      if ($urandom_range(0, 1) == 0) rq.pos = POS_BITS'($urandom_range(lim, DEPTH - 1));
      else rq.right = POS_BITS'($urandom_range(lim, DEPTH - 1));
    end
    return rq;
  endfunction

  task automatic send_request(input request_t rq, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     res;
    gap = pick_gap(quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= rq.op;
    position_i  <= rq.pos;
    right_end_i <= rq.right;
    value_i     <= rq.val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_result(rq, res);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    if (rq.op == OP_SET) n_sets++;
    else n_queries++;
    if (res.status != STAT_OK) n_rejected++;
  endtask

  task automatic write_count(input logic [COUNT_BITS-1:0] count);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_count = count;
    n_settings++;
  endtask

  task automatic add_req(input op_e op, input int pos, input int right,
                         input logic [FIELD_BITS-1:0] val, input bit typed,
                         input logic [FIELD_BITS-1:0] sum, input status_e status);
    plan_row_t row;
    row.kind       = ROW_REQ;
    row.req.op     = op;
    row.req.pos    = POS_BITS'(pos);
    row.req.right  = POS_BITS'(right);
    row.req.val    = val;
    row.count      = '0;
    row.typed      = typed;
    row.res.sum    = sum;
    row.res.status = status;
    stimulus_plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [COUNT_BITS-1:0] count);
    plan_row_t row;
    row.kind       = ROW_CFG;
    row.req.op     = OP_SET;
    row.req.pos    = '0;
    row.req.right  = '0;
    row.req.val    = '0;
    row.count      = count;
    row.typed      = 1'b0;
    row.res.sum    = '0;
    row.res.status = STAT_OK;
    stimulus_plan.push_back(row);
  endtask

  // receiver: runs of ready cycles broken by stalls of random length
  initial begin
    int unsigned run;
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      hold = pick_gap(1'b0);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: sum %h status %0d",
                 $time, range_sum_o, status_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (range_sum_o !== want.sum) begin
          $display("%0t: range_sum mismatch: expected %h, got %h", $time, want.sum, range_sum_o);
          n_errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL range_sum_point_set_store");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    result_t               dummy;
    request_t              rq;
    logic [COUNT_BITS-1:0] counts [7];
    int                    lengths [7];
    int unsigned           lim;

    for (int k = 0; k < DEPTH; k++) point_value[k] = '0;
    cur_count = ACTIVE_RESET;
    dummy.sum = '0;
    dummy.status = STAT_OK;

    // directed table: extremes, wrap, error codes, ignored fields, count edge settings
    add_req(OP_QUERY, 0, 1023, 32'h0, 1, 32'h0, STAT_OK);
    add_req(OP_SET, 0, 0, 32'h7fff_ffff, 1, 32'h0, STAT_OK);
    add_req(OP_SET, 1023, 0, 32'h8000_0000, 1, 32'h0, STAT_OK);
    add_req(OP_QUERY, 0, 0, 32'h0, 1, 32'h7fff_ffff, STAT_OK);
    add_req(OP_QUERY, 1023, 1023, 32'h0, 1, 32'h8000_0000, STAT_OK);
    add_req(OP_QUERY, 0, 1023, 32'h0, 1, 32'hffff_ffff, STAT_OK);
    add_req(OP_SET, 1, 0, 32'h1, 1, 32'h0, STAT_OK);
    add_req(OP_QUERY, 0, 1, 32'h0, 1, 32'h8000_0000, STAT_OK);
    add_req(OP_QUERY, 5, 3, 32'h0, 1, 32'h0, STAT_ORDER);
    add_req(OP_QUERY, 1023, 0, 32'h0, 1, 32'h0, STAT_ORDER);
    add_req(OP_SET, 512, 0, 32'hffff_ffff, 1, 32'h0, STAT_OK);
    add_req(OP_SET, 512, 0, 32'h5, 1, 32'h0, STAT_OK);
    add_req(OP_QUERY, 512, 512, 32'h0, 1, 32'h5, STAT_OK);
    add_req(OP_SET, 3, 1023, 32'h5555_aaaa, 1, 32'h0, STAT_OK);
    add_req(OP_QUERY, 3, 3, 32'h1234_5678, 1, 32'h5555_aaaa, STAT_OK);
    add_req(OP_QUERY, 1, 1022, 32'h0, 0, 32'h0, STAT_OK);
    add_req(OP_SET, 1022, 0, 32'h2aaa_5555, 1, 32'h0, STAT_OK);
    add_req(OP_QUERY, 0, 1023, 32'h0, 0, 32'h0, STAT_OK);
    add_cfg(11'd1);
    add_req(OP_SET, 0, 0, 32'h9, 1, 32'h0, STAT_OK);
    add_req(OP_SET, 1, 0, 32'h3, 1, 32'h0, STAT_RANGE);
    add_req(OP_QUERY, 0, 1, 32'h0, 1, 32'h0, STAT_RANGE);
    // out of range wins over a reversed range
    add_req(OP_QUERY, 1, 0, 32'h0, 1, 32'h0, STAT_RANGE);
    add_req(OP_QUERY, 0, 0, 32'h0, 1, 32'h9, STAT_OK);
    add_cfg(11'd0);
    add_req(OP_SET, 0, 0, 32'h1, 1, 32'h0, STAT_RANGE);
    add_req(OP_QUERY, 0, 0, 32'h0, 1, 32'h0, STAT_RANGE);
    add_cfg(11'd2047);
    add_req(OP_QUERY, 1023, 1023, 32'h0, 1, 32'h8000_0000, STAT_OK);
    add_req(OP_QUERY, 1, 1023, 32'h0, 0, 32'h0, STAT_OK);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stimulus_plan[i]) begin
      if (stimulus_plan[i].kind == ROW_CFG) write_count(stimulus_plan[i].count);
      else send_request(stimulus_plan[i].req, stimulus_plan[i].typed, stimulus_plan[i].res);
    end

    counts  = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd2, 11'd1023, 11'd1024};
    lengths = '{500, 120, 300, 40, 300, 200, 290};
    counts[4] = COUNT_BITS'($urandom_range(2, 1022));
    for (int p = 0; p < 7; p++) begin
      write_count(counts[p]);
      lim = (cur_count > DEPTH) ? DEPTH : cur_count;
      for (int n = 0; n < lengths[p]; n++) begin
        if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        rq = make_request(lim);
        send_request(rq, 1'b0, dummy);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("ran %0d sets and %0d queries (%0d rejected) over %0d active count settings",
             n_sets, n_queries, n_rejected, n_settings);
    $display("%0d results checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS range_sum_point_set_store");
    end else begin
      $display("FAIL range_sum_point_set_store");
    end
    $finish;
  end

endmodule

// File: range_sum_point_set_store.f
hw/rtl/rsps_pkg.sv
hw/rtl/rsps_store.sv
hw/rtl/rsps_seq.sv
hw/rtl/range_sum_point_set_store.sv
bench/tb.sv
